>>> hdl/deq_pkg.sv
`default_nettype none

package deq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] elem_t;

	typedef enum logic [2:0] {
		CMD_PEEK       = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_PUSH_BACK  = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_POP_BACK   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]          cmd;
		logic signed [31:0]  value;
	} req_item_t;

	typedef struct packed {
		logic [1:0]          status;
		logic signed [31:0]  popped_value;
		logic signed [31:0]  front_value;
		logic signed [31:0]  rear_value;
		logic [4:0]          item_count;
		logic                is_empty;
	} rsp_item_t;

	function automatic idx_t wrap_add(idx_t i, cnt_t n);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(i) + (CNT_W + 1)'(n);
		if (s >= (CNT_W + 1)'(DEPTH)) begin
			s = s - (CNT_W + 1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic idx_t wrap_inc(idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic idx_t wrap_dec(idx_t i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
	endfunction

	function automatic elem_t to_elem(logic [31:0] v);
		logic [63:0] t;
		t = 64'(v);
		return t[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] to_field(elem_t e);
		logic [63:0] t;
		t = 64'(e);
		return t[31:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/double_ended_queue.sv
// An accepted item passes through the s1 stage registers and then the rsp register before its result is on rsp.
// Throughput: one item per cycle while rsp is not stalled; the element that becomes the new front or rear
// after a pop is read from the registered port of the slot memory and is forwarded.
// Reset clears the front pointer, the element count and all valid flags.
// Slot storage is not cleared; data read from a slot that holds no element is never used.
`default_nettype none

module double_ended_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output      logic               req_ready,
	input  wire deq_pkg::req_item_t req,
	output      logic               rsp_valid,
	input  wire logic               rsp_ready,
	output      deq_pkg::rsp_item_t rsp
);

	import deq_pkg::*;

	idx_t      head_q;
	cnt_t      count_q;
	elem_t     front_q;
	elem_t     rear_q;

	logic      s1_valid;
	status_t   s1_status;
	elem_t     s1_popped;
	cnt_t      s1_count;
	logic      s1_ld_front;
	logic      s1_ld_rear;

	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	logic      s1_fire;
	logic      acc;
	elem_t     rdata;
	elem_t     eff_front;
	elem_t     eff_rear;

	idx_t      nxt_head;
	cnt_t      nxt_count;
	elem_t     nxt_front;
	elem_t     nxt_rear;
	status_t   nxt_status;
	elem_t     nxt_popped;
	logic      nxt_ld_front;
	logic      nxt_ld_rear;
	logic      we;
	idx_t      waddr;
	elem_t     wdata;
	logic      re;
	idx_t      raddr;
	logic      full;
	logic      empty;

	assign s1_fire   = s1_valid && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid || s1_fire;
	assign acc       = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign eff_front = (s1_valid && s1_ld_front) ? rdata : front_q;
	assign eff_rear  = (s1_valid && s1_ld_rear) ? rdata : rear_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		nxt_head     = head_q;
		nxt_count    = count_q;
		nxt_front    = eff_front;
		nxt_rear     = eff_rear;
		nxt_status   = ST_OK;
		nxt_popped   = '0;
		nxt_ld_front = 1'b0;
		nxt_ld_rear  = 1'b0;
		we           = 1'b0;
		waddr        = wrap_dec(head_q);
		wdata        = to_elem(req.value);
		re           = 1'b0;
		raddr        = head_q;
		case (req.cmd)
			CMD_PUSH_FRONT: begin
				if (full) begin
					nxt_status = ST_FULL;
				end else begin
					we        = 1'b1;
					waddr     = wrap_dec(head_q);
					nxt_head  = wrap_dec(head_q);
					nxt_count = count_q + CNT_W'(1);
					nxt_front = wdata;
					if (empty) begin
						nxt_rear = wdata;
					end
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					nxt_status = ST_FULL;
				end else begin
					we        = 1'b1;
					waddr     = wrap_add(head_q, count_q);
					nxt_count = count_q + CNT_W'(1);
					nxt_rear  = wdata;
					if (empty) begin
						nxt_front = wdata;
					end
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					nxt_status = ST_EMPTY;
				end else begin
					nxt_popped   = eff_front;
					re           = 1'b1;
					raddr        = wrap_inc(head_q);
					nxt_head     = wrap_inc(head_q);
					nxt_count    = count_q - CNT_W'(1);
					nxt_ld_front = (count_q != CNT_W'(1));
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					nxt_status = ST_EMPTY;
				end else begin
					nxt_popped  = eff_rear;
					re          = 1'b1;
					raddr       = (count_q < CNT_W'(2)) ? head_q :
						wrap_add(head_q, count_q - CNT_W'(2));
					nxt_count   = count_q - CNT_W'(1);
					nxt_ld_rear = (count_q != CNT_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	deq_ram #(
		.DEPTH(DEPTH),
		.WIDTH(DATA_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (we && acc),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re && acc),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			s1_valid    <= 1'b0;
			s1_ld_front <= 1'b0;
			s1_ld_rear  <= 1'b0;
		end else begin
			if (acc) begin
				head_q      <= nxt_head;
				count_q     <= nxt_count;
				s1_valid    <= 1'b1;
				s1_ld_front <= nxt_ld_front;
				s1_ld_rear  <= nxt_ld_rear;
			end else if (s1_fire) begin
				s1_valid    <= 1'b0;
				s1_ld_front <= 1'b0;
				s1_ld_rear  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			front_q   <= nxt_front;
			rear_q    <= nxt_rear;
			s1_status <= nxt_status;
			s1_popped <= nxt_popped;
			s1_count  <= nxt_count;
		end else begin
			front_q <= eff_front;
			rear_q  <= eff_rear;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rsp_q.status       <= s1_status;
			rsp_q.popped_value <= to_field(s1_popped);
			rsp_q.front_value  <= (s1_count != '0) ? to_field(eff_front) : '0;
			rsp_q.rear_value   <= (s1_count != '0) ? to_field(eff_rear) : '0;
			rsp_q.item_count   <= 5'(s1_count);
			rsp_q.is_empty     <= (s1_count == '0);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count exceeds depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= IDX_W'(DEPTH - 1))
		else $error("front pointer out of range");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !full && (req.cmd == CMD_PUSH_FRONT || req.cmd == CMD_PUSH_BACK))
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted push did not grow the queue");

	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && (s1_ld_front || s1_ld_rear)) |-> (s1_count != '0))
		else $error("memory forward pending on an empty queue");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.is_empty == (rsp_q.item_count == 5'd0)))
		else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

>>> hdl/deq_ram.sv
`default_nettype none

module deq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
